// ===== rtl/core/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, constants and elaboration-time table builders for the
// log-odds profile row unit.
// ----------------------------------------------------------------------------
package smx_pkg;

	localparam int unsigned LOG2E_Q16 = 94548;
	localparam int unsigned ZERO_P_Y  = 150 * 65536;
	localparam int unsigned REC_TAIL  = 5;
	localparam logic [6:0]  SCALE_RST = 7'd8;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_EXP_Y,
		ST_EXP_STEP,
		ST_EXP_ACC,
		ST_LOG_NORM,
		ST_LOG_SQ,
		ST_SC_Y,
		ST_SC_L,
		ST_SC_MUL,
		ST_SC_OUT,
		ST_TAIL
	} smx_state_t;

	function automatic longint unsigned isqrt64(input longint unsigned v);
		longint unsigned res;
		longint unsigned bit_w;
		longint unsigned x;
		res = 0;
		x = v;
		bit_w = 64'd1 << 62;
		while (bit_w > x) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (x >= res + bit_w) begin
				x = x - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic longint log2_q16(input longint unsigned v);
		int k;
		longint unsigned x;
		longint unsigned frac;
		k = 0;
		frac = 0;
		if (v == 0) return 0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) k = i;
		end
		x = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				frac = frac | 64'd1;
				x = x >> 1;
			end
		end
		return longint'((64'(k) << 16) + frac);
	endfunction

	// 2^(-2^-k) in q30
	function automatic longint unsigned pow_q30(input int k);
		longint unsigned r;
		r = isqrt64(64'd1 << 59);
		for (int j = 2; j <= k; j++) r = isqrt64(r << 30);
		return r;
	endfunction

	function automatic longint unsigned bg_scaled(input int i);
		longint unsigned b;
		case (i)
			0:       b = 489372;
			1:       b = 306991;
			2:       b = 1010490;
			3:       b = 329671;
			4:       b = 276149;
			5:       b = 416262;
			6:       b = 452521;
			7:       b = 308760;
			8:       b = 297251;
			9:       b = 607036;
			10:      b = 150238;
			11:      b = 215826;
			12:      b = 783843;
			13:      b = 512926;
			14:      b = 264886;
			15:      b = 610702;
			16:      b = 201311;
			17:      b = 2159980;
			18:      b = 310265;
			19:      b = 295417;
			default: b = 500000;
		endcase
		return b;
	endfunction

	function automatic longint bg_log_q16(input int i);
		return log2_q16(bg_scaled(i)) - log2_q16(64'd10000000);
	endfunction

endpackage

// ===== rtl/core/smx_if.sv =====
// ----------------------------------------------------------------------------
// smx_if
// Valid/ready channels of the log-odds profile row unit.
// ----------------------------------------------------------------------------
interface smx_in_if #(parameter int LOGIT_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [LOGIT_WIDTH-1:0] logit_value;

	modport source(output valid, output logit_value, input ready);
	modport sink(input valid, input logit_value, output ready);
endinterface

interface smx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       record_last;

	modport source(output valid, output out_byte, output record_last, input ready);
	modport sink(input valid, input out_byte, input record_last, output ready);
endinterface

// ===== rtl/core/smx_mul.sv =====
// ----------------------------------------------------------------------------
// smx_mul
// Shared unsigned multiplier that forms every product of the row unit.
// ----------------------------------------------------------------------------
module smx_mul #(
	parameter int W = 32
) (
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p
);
	assign p = (2*W)'(a) * (2*W)'(b);
endmodule

// ===== rtl/core/softmax_log_odds_profile_row_unit.sv =====
// ----------------------------------------------------------------------------
// softmax_log_odds_profile_row_unit
// Collects one row of class logits, forms the fixed-point softmax and emits
// a record of saturated log-odds scores, the consensus class and padding.
// ----------------------------------------------------------------------------
//  channel  dir  payload                    handshake
//  in_ch    in   logit_value (Q8.8 signed)  valid/ready, one logit per beat
//  out_ch   out  out_byte, record_last      valid/ready, one record byte per beat
//  cfg      in   cfg_wdata = score_scale    cfg_we, single cycle write
//
// one logit per cycle while loading; after the last logit the row forms
// the exp term of each class (16-step factor loop on the shared
// multiplier), then log2 of the sum, then the score beats and the tail
// beats of the record.
// in_ch.ready is high only while loading; output stalls simply hold the beat.
// reset clears control state and sets score_scale to 8.
// ----------------------------------------------------------------------------
module softmax_log_odds_profile_row_unit #(
	parameter int NUM_CLASSES = 20,
	parameter int LOGIT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	smx_in_if.sink     in_ch,
	smx_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);
	import smx_pkg::*;

	localparam int IW  = $clog2(NUM_CLASSES);
	localparam int DW  = LOGIT_WIDTH + 1;
	localparam int YW  = (LOGIT_WIDTH + 10 > 25) ? LOGIT_WIDTH + 10 : 25;
	localparam int MW  = (DW > 32) ? DW : 32;
	localparam int PW  = 2 * MW;
	localparam int NW  = YW - 16;
	localparam int LW  = 27;

	smx_state_t state_q, state_d;

	logic signed [LOGIT_WIDTH-1:0] logit_q [NUM_CLASSES];
	logic signed [LOGIT_WIDTH-1:0] max_q;
	logic [IW-1:0]  max_idx_q;
	logic [IW-1:0]  cnt_q;
	logic [IW-1:0]  idx_q;
	logic [YW-1:0]  y_q;
	logic [30:0]    r_q;
	logic [3:0]     step_q;
	logic [23:0]    sum_q;
	logic [23:0]    nv_q;
	logic [4:0]     lk_q;
	logic [30:0]    xs_q;
	logic [15:0]    frac_q;
	logic [19:0]    lsum_q;
	logic [LW-1:0]  lmag_q;
	logic           lneg_q;
	logic           zp_q;
	logic [2:0]     tail_q;
	logic [6:0]     scale_q;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           last_q;

	logic [30:0]        pow_rom [16];
	logic signed [23:0] bg_log  [NUM_CLASSES];

	for (genvar g = 0; g < 16; g++) begin : g_pow
		localparam longint unsigned PV = pow_q30(g + 1);
		assign pow_rom[g] = PV[30:0];
	end

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_bg
		localparam longint LB = bg_log_q16(g);
		assign bg_log[g] = LB[23:0];
	end

	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] prod;

	smx_mul #(.W(MW)) u_mul (.a(mul_a), .b(mul_b), .p(prod));

	// distance below the row maximum, never negative
	logic [DW-1:0] gap;
	assign gap = DW'($signed({max_q[LOGIT_WIDTH-1], max_q})
		- $signed({logit_q[idx_q][LOGIT_WIDTH-1], logit_q[idx_q]}));

	logic [YW-1:0] y_next;
	assign y_next = YW'((prod + PW'(128)) >> 8);

	// exp term from the finished factor product
	logic [NW-1:0] y_int;
	logic [16:0]   e_term;
	assign y_int  = y_q[YW-1:16];
	always_comb begin
		if (y_int >= NW'(17)) begin
			e_term = '0;
		end else begin
			e_term = 17'((32'(r_q) + (32'd1 << (5'd13 + 5'(y_int))))
				>> (5'd14 + 5'(y_int)));
		end
	end

	logic [31:0] sq;
	assign sq = prod[61:30];
	logic [15:0] frac_next;
	assign frac_next = {frac_q[14:0], sq[31]};

	logic        in_acc, out_acc;
	logic        last_cls, last_load;
	assign in_acc    = in_ch.valid & in_ch.ready;
	assign out_acc   = out_ch.valid & out_ch.ready;
	assign last_cls  = (idx_q == IW'(NUM_CLASSES - 1));
	assign last_load = (cnt_q == IW'(NUM_CLASSES - 1));

	// log2 odds for the current class
	logic signed [LW-1:0] l_val;
	assign l_val = -$signed({3'b000, y_q[23:0]}) - $signed({7'b0, lsum_q})
		- $signed({{3{bg_log[idx_q][23]}}, bg_log[idx_q]});

	logic [PW-1:0] rnd;
	logic [7:0]    score;
	assign rnd = (prod + PW'(32768)) >> 16;
	always_comb begin
		if (zp_q) begin
			score = (scale_q != '0) ? 8'h80 : 8'h00;
		end else if (lneg_q) begin
			score = (rnd > PW'(128)) ? 8'h80 : 8'(~rnd[7:0] + 8'd1);
		end else begin
			score = (rnd > PW'(127)) ? 8'h7f : rnd[7:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (in_acc && last_load) state_d = ST_EXP_Y;
			ST_EXP_Y:    state_d = ST_EXP_STEP;
			ST_EXP_STEP: if (step_q == 4'd15) state_d = ST_EXP_ACC;
			ST_EXP_ACC:  state_d = last_cls ? ST_LOG_NORM : ST_EXP_Y;
			ST_LOG_NORM: if (nv_q[23]) state_d = ST_LOG_SQ;
			ST_LOG_SQ:   if (step_q == 4'd15) state_d = ST_SC_Y;
			ST_SC_Y:     state_d = ST_SC_L;
			ST_SC_L:     state_d = ST_SC_MUL;
			ST_SC_MUL:   state_d = ST_SC_OUT;
			ST_SC_OUT:   if (out_acc) state_d = last_cls ? ST_TAIL : ST_SC_Y;
			ST_TAIL:     if (out_acc && tail_q == 3'(REC_TAIL - 1)) state_d = ST_LOAD;
			default:     state_d = ST_LOAD;
		endcase
	end

	// outputs and shared multiplier operands
	always_comb begin
		in_ch.ready = (state_q == ST_LOAD);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EXP_Y, ST_SC_Y: begin
				mul_a = MW'(gap);
				mul_b = MW'(LOG2E_Q16);
			end
			ST_EXP_STEP: begin
				mul_a = MW'(r_q);
				mul_b = MW'(pow_rom[step_q]);
			end
			ST_LOG_SQ: begin
				mul_a = MW'(xs_q);
				mul_b = MW'(xs_q);
			end
			ST_SC_MUL: begin
				mul_a = MW'(lmag_q);
				mul_b = MW'(scale_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.record_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			max_q       <= {1'b1, {(LOGIT_WIDTH-1){1'b0}}};
			max_idx_q   <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			tail_q      <= '0;
			scale_q     <= SCALE_RST;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) scale_q <= cfg_wdata;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (in_ch.logit_value > max_q) begin
							max_q     <= in_ch.logit_value;
							max_idx_q <= cnt_q;
						end
						cnt_q  <= last_load ? '0 : cnt_q + IW'(1);
						idx_q  <= '0;
						step_q <= '0;
					end
				end
				ST_EXP_STEP: step_q <= step_q + 4'd1;
				ST_EXP_ACC: begin
					idx_q  <= last_cls ? '0 : idx_q + IW'(1);
					step_q <= '0;
				end
				ST_LOG_SQ: step_q <= step_q + 4'd1;
				ST_SC_OUT: begin
					if (out_acc) begin
						if (last_cls) begin
							tail_q <= '0;
						end else begin
							idx_q       <= idx_q + IW'(1);
							out_valid_q <= 1'b0;
						end
					end
				end
				ST_SC_MUL: out_valid_q <= 1'b1;
				ST_TAIL: begin
					if (out_acc) begin
						tail_q <= tail_q + 3'd1;
						if (tail_q == 3'(REC_TAIL - 1)) begin
							out_valid_q <= 1'b0;
							last_q      <= 1'b0;
							max_q       <= {1'b1, {(LOGIT_WIDTH-1){1'b0}}};
							max_idx_q   <= '0;
							idx_q       <= '0;
						end else begin
							last_q <= (tail_q == 3'(REC_TAIL - 2));
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (in_acc) logit_q[cnt_q] <= in_ch.logit_value;
				sum_q <= '0;
			end
			ST_EXP_Y: begin
				y_q <= y_next;
				r_q <= 31'h4000_0000;
			end
			ST_EXP_STEP: begin
				if (y_q[4'd15 - step_q]) r_q <= 31'((prod + PW'(32'h2000_0000)) >> 30);
			end
			ST_EXP_ACC: begin
				sum_q <= sum_q + 24'(e_term);
				nv_q  <= sum_q + 24'(e_term);
				lk_q  <= 5'd23;
			end
			ST_LOG_NORM: begin
				if (nv_q[23]) begin
					xs_q   <= {nv_q, 7'b0};
					frac_q <= '0;
				end else begin
					nv_q <= {nv_q[22:0], 1'b0};
					lk_q <= lk_q - 5'd1;
				end
			end
			ST_LOG_SQ: begin
				frac_q <= frac_next;
				xs_q   <= sq[31] ? sq[31:1] : sq[30:0];
				lsum_q <= {1'b0, 3'(lk_q - 5'd16), frac_next};
			end
			ST_SC_Y: y_q <= y_next;
			ST_SC_L: begin
				zp_q   <= (y_q >= YW'(ZERO_P_Y));
				lneg_q <= l_val[LW-1];
				lmag_q <= l_val[LW-1] ? LW'(-l_val) : LW'(l_val);
			end
			ST_SC_MUL: out_byte_q <= score;
			ST_SC_OUT: begin
				if (out_acc && last_cls) out_byte_q <= 8'(max_idx_q);
			end
			ST_TAIL: begin
				if (out_acc) out_byte_q <= (tail_q == 3'd0) ? 8'(max_idx_q) : 8'h00;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/smx_chk.sv =====
// ----------------------------------------------------------------------------
// smx_chk
// Port-level checks for the log-odds profile row unit, bound to the top.
// ----------------------------------------------------------------------------
module smx_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       record_last
);
	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(record_last))
		else $error("output beat changed under stall");

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a record beat is pending");

	// the record ends cleanly
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && record_last |=> !out_valid)
		else $error("beat after the last record byte");

	// loading stops only on an accepted logit
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("input ready dropped without a beat");
endmodule

bind softmax_log_odds_profile_row_unit smx_chk u_smx_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_byte    (out_ch.out_byte),
	.record_last (out_ch.record_last)
);
